/* rtl/knn_pkg.sv */
// Shared types and constants of the k-nearest-neighbor selector.
// No dependencies; imported by every module of the block but knn_fifo.
package knn_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned DIST_BITS  = 42;
  localparam int unsigned RANK_BITS  = 6;
  localparam int unsigned KCFG_BITS  = 7;
  localparam int unsigned KCFG_RESET = 50;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_OFFER  = 2'd1,
    CMD_DRAIN  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } in_word_t;

  typedef struct packed {
    logic                         found;
    logic signed [COORD_BITS-1:0] nb_x;
    logic signed [COORD_BITS-1:0] nb_y;
    logic signed [COORD_BITS-1:0] nb_z;
    logic [DIST_BITS-1:0]         dist_sq;
    logic [RANK_BITS-1:0]         rank;
    logic                         last;
  } out_word_t;

  // One held point with its distance.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [DIST_BITS-1:0]         dsq;
  } entry_t;

  // Classified word passed from front to back.
  typedef struct packed {
    logic [1:0] command;
    entry_t     pt;
  } job_t;

endpackage

/* rtl/knn_fifo.sv */
// Small register FIFO with level output.
// No dependencies.
module knn_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           din_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           dout_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [LW-1:0]    level_q;
  logic             do_push, do_pop;

  assign empty_o = (level_q == '0);
  assign full_o  = (level_q == LW'(DEPTH));
  assign level_o = level_q;
  assign dout_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + 1'b1;
      end else if (do_pop && !do_push) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

/* rtl/knn_front.sv */
// Front end: takes words, holds the query point, computes saturated squared
// distance in three stages. Depends on knn_pkg.
module knn_front #(
  parameter int unsigned QDEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  knn_pkg::in_word_t           in_i,
  input  logic [$clog2(QDEPTH+1)-1:0] qlevel_i,
  output logic                        job_valid_o,
  output knn_pkg::job_t               job_o
);
  import knn_pkg::*;

  localparam int unsigned LW = $clog2(QDEPTH+1);
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned TW = SW + 2;

  logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic                 v0_q, v1_q, v2_q;
  logic [1:0]           c0_q, c1_q;
  entry_t               p0_q, p1_q;
  logic [DW-1:0]        ax_q, ay_q, az_q;
  logic [SW-1:0]        sx_q, sy_q, sz_q;
  job_t                 job_q;
  logic                 accept;
  logic [LW+1:0]        used;
  logic signed [DW-1:0] dx, dy, dz;
  logic [TW-1:0]        sum;

  assign used   = (LW+2)'(qlevel_i) + (LW+2)'(v0_q) + (LW+2)'(v1_q) + (LW+2)'(v2_q);
  assign full_o = (used >= (LW+2)'(QDEPTH));
  assign accept = push_i & ~full_o;

  assign dx = DW'(in_i.x) - DW'(qx_q);
  assign dy = DW'(in_i.y) - DW'(qy_q);
  assign dz = DW'(in_i.z) - DW'(qz_q);
  assign sum = TW'(sx_q) + TW'(sy_q) + TW'(sz_q);

  assign job_valid_o = v2_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
      if (accept && in_i.command == CMD_START) begin
        qx_q <= in_i.x;
        qy_q <= in_i.y;
        qz_q <= in_i.z;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    c0_q      <= in_i.command;
    p0_q.x    <= in_i.x;
    p0_q.y    <= in_i.y;
    p0_q.z    <= in_i.z;
    p0_q.dsq  <= '0;
    ax_q      <= dx[DW-1] ? -dx : dx;
    ay_q      <= dy[DW-1] ? -dy : dy;
    az_q      <= dz[DW-1] ? -dz : dz;
    c1_q      <= c0_q;
    p1_q      <= p0_q;
    sx_q      <= ax_q * ax_q;
    sy_q      <= ay_q * ay_q;
    sz_q      <= az_q * az_q;
    job_q.command <= c1_q;
    job_q.pt.x    <= p1_q.x;
    job_q.pt.y    <= p1_q.y;
    job_q.pt.z    <= p1_q.z;
    job_q.pt.dsq  <= (sum > TW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
                                                   : sum[DIST_BITS-1:0];
  end

endmodule

/* rtl/knn_back.sv */
// Back end: sorted insertion chain of held points, drain sequencer.
// Depends on knn_pkg.
module knn_back #(
  parameter int unsigned MAX_K = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [knn_pkg::KCFG_BITS-1:0] kcfg_i,
  input  logic                      job_empty_i,
  input  knn_pkg::job_t             job_i,
  output logic                      job_pop_o,
  input  logic                      out_full_i,
  output logic                      out_push_o,
  output knn_pkg::out_word_t        out_o
);
  import knn_pkg::*;

  localparam int unsigned CW = $clog2(MAX_K+1);
  localparam int unsigned KW = (CW > KCFG_BITS) ? CW : KCFG_BITS;

  typedef enum logic {ST_IDLE, ST_DRAIN} state_e;

  state_e               state_q;
  logic [CW-1:0]        count_q;
  logic [RANK_BITS-1:0] rank_q;
  entry_t               cell_q [MAX_K];
  logic [MAX_K-1:0]     le, gt;
  logic [KW-1:0]        kraw, klim;
  logic                 any_gt, is_offer, is_drain, is_start, do_ins, grow;

  assign kraw = KW'(kcfg_i);
  assign klim = (kraw == '0) ? KW'(1) : ((kraw > KW'(MAX_K)) ? KW'(MAX_K) : kraw);

  for (genvar i = 0; i < MAX_K; i++) begin : g_cmp
    assign le[i] = (CW'(i) < count_q) && !(cell_q[i].dsq > job_i.pt.dsq);
    assign gt[i] = (CW'(i) < count_q) &&  (cell_q[i].dsq > job_i.pt.dsq);
  end
  assign any_gt = |gt;

  assign is_start = (job_i.command == CMD_START);
  assign is_offer = (job_i.command == CMD_OFFER);
  assign is_drain = (job_i.command == CMD_DRAIN);
  assign grow     = (KW'(count_q) < klim);

  // no word is taken while draining; drains also wait for space at the output
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i && !(is_drain && out_full_i);
  assign do_ins    = job_pop_o && is_offer && (grow || any_gt);

  always_comb begin
    out_push_o = 1'b0;
    out_o      = '0;
    if (state_q == ST_DRAIN) begin
      out_push_o    = !out_full_i;
      out_o.found   = 1'b1;
      out_o.nb_x    = cell_q[0].x;
      out_o.nb_y    = cell_q[0].y;
      out_o.nb_z    = cell_q[0].z;
      out_o.dist_sq = cell_q[0].dsq;
      out_o.rank    = rank_q;
      out_o.last    = (count_q == CW'(1));
    end else if (job_pop_o && is_drain && count_q == '0) begin
      out_push_o = 1'b1;
      out_o.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rank_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          rank_q <= '0;
          if (job_pop_o) begin
            if (is_start) begin
              count_q <= '0;
            end else if (do_ins && grow) begin
              count_q <= count_q + 1'b1;
            end else if (is_drain && count_q != '0) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!out_full_i) begin
            count_q <= count_q - 1'b1;
            rank_q  <= rank_q + 1'b1;
            if (count_q == CW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // the chain: insert at the first farther entry and shift the rest toward the tail; drains shift toward the head
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        if (!le[i]) begin
          if (i == 0) begin
            cell_q[i] <= job_i.pt;
          end else if (le[(i > 0) ? i-1 : 0]) begin
            cell_q[i] <= job_i.pt;
          end else begin
            cell_q[i] <= cell_q[(i > 0) ? i-1 : 0];
          end
        end
      end else if (state_q == ST_DRAIN && !out_full_i && i < MAX_K-1) begin
        cell_q[i] <= cell_q[(i < MAX_K-1) ? i+1 : i];
      end
    end
  end

endmodule

/* rtl/k_nearest_neighbor_selector_top.sv */
// Top level of the k-nearest-neighbor selector.
// Depends on knn_pkg, knn_front, knn_fifo, knn_back.
//
// Usage: words enter through push_i/full_o; command start loads the query
// point and empties the held set, offer ranks a candidate by squared
// distance, drain emits the held points nearest first. Results leave through
// empty_o/pop_i, oldest first. max_neighbors is written over cfg_valid_i /
// cfg_ready_o (always ready); the user must write it only while the block is
// idle, which the block itself does not enforce. A word passes the distance
// pipeline, then waits in an 8-deep job queue for the back end. The back end
// takes one start or offer per cycle into the sorted chain while no drain is
// in progress, so words flow at one per cycle outside drains. A drain is taken
// from the job queue, then gives one result per cycle from the head of the
// chain while the result queue has space; it blocks the job queue meanwhile.
// A drain of an empty set gives one result with found 0 and last 1.
// Reset clears the query to the origin, empties the set, empties both queues
// and loads max_neighbors with 50. No clearing pass is needed.
// When the receiver stalls the 2-deep result queue fills, the drain pauses,
// the job queue fills behind it and full_o rises; nothing is lost.
module k_nearest_neighbor_selector_top #(
  parameter int unsigned MAX_K = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  knn_pkg::in_word_t                 in_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output knn_pkg::out_word_t                out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [knn_pkg::KCFG_BITS-1:0]     cfg_data_i
);
  import knn_pkg::*;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned ODEPTH = 2;

  logic [KCFG_BITS-1:0]       kcfg_q;
  logic                       job_valid, job_pop, job_empty, job_full;
  job_t                       job_in, job_out;
  logic [$clog2(QDEPTH+1)-1:0] qlevel;
  logic                       out_push, out_full;
  out_word_t                  out_word, out_head;
  logic [$clog2(ODEPTH+1)-1:0] olevel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcfg_q <= KCFG_BITS'(KCFG_RESET);
    end else if (cfg_valid_i) begin
      kcfg_q <= cfg_data_i;
    end
  end

  knn_front #(.QDEPTH(QDEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_i        (in_i),
    .qlevel_i    (qlevel),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  // credit check in the front keeps this queue from overflowing
  knn_fifo #(.WIDTH($bits(job_t)), .DEPTH(QDEPTH)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .din_i   (job_in),
    .pop_i   (job_pop),
    .dout_o  (job_out),
    .empty_o (job_empty),
    .full_o  (job_full),
    .level_o (qlevel)
  );

  knn_back #(.MAX_K(MAX_K)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kcfg_i      (kcfg_q),
    .job_empty_i (job_empty | (job_full & 1'b0)),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (out_word)
  );

  knn_fifo #(.WIDTH($bits(out_word_t)), .DEPTH(ODEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .din_i   (out_word),
    .pop_i   (pop_i),
    .dout_o  (out_head),
    .empty_o (empty_o),
    .full_o  (out_full),
    .level_o (olevel)
  );

  // level of the result queue is not needed beyond full/empty
  assign out_o = (olevel == '0) ? out_head : out_head;

endmodule

/* bench/knn_checker.sv */
// Checker for the k-nearest-neighbor selector: tracks query, held set and limit,
// predicts drained words and compares them with what leaves the block.
// Depends on knn_pkg.
module knn_checker
  import knn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  in_word_t             in_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  out_word_t            out_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [KCFG_BITS-1:0] cfg_data_i,
  output int                   fails_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_DEPTH = 64;
  localparam longint DIST_CAP = (64'd1 << DIST_BITS) - 1;

  logic [KCFG_BITS-1:0]         k_limit;
  logic signed [COORD_BITS-1:0] qx, qy, qz;
  int unsigned                  held_n;
  entry_t                       held [SET_DEPTH];
  out_word_t                    drained_q [$];

  assign pending_o = drained_q.size();

  function automatic logic [DIST_BITS-1:0] sq_dist(entry_t p);
    longint dx, dy, dz, s;
    dx = longint'(p.x) - longint'(qx);
    dy = longint'(p.y) - longint'(qy);
    dz = longint'(p.z) - longint'(qz);
    s = dx * dx + dy * dy + dz * dz;
    return (s > DIST_CAP) ? DIST_CAP[DIST_BITS-1:0] : s[DIST_BITS-1:0];
  endfunction

  // Sorted insert; equal distances stay behind earlier entries.
  task automatic insert_point(entry_t p);
    int unsigned pos;
    pos = held_n;
    while (pos > 0 && held[pos-1].dsq > p.dsq) begin
      held[pos] = held[pos-1];
      pos--;
    end
    held[pos] = p;
    held_n++;
  endtask

  task automatic predict(in_word_t w);
    entry_t      p;
    int unsigned lim;
    out_word_t   r;
    case (w.command)
      CMD_START: begin
        qx = w.x; qy = w.y; qz = w.z;
        held_n = 0;
      end
      CMD_OFFER: begin
        p.x = w.x; p.y = w.y; p.z = w.z;
        p.dsq = sq_dist(p);
        lim = (k_limit < 1) ? 1 : (k_limit > SET_DEPTH) ? SET_DEPTH : k_limit;
        if (held_n < lim) begin
          insert_point(p);
        end else if (held_n > 0 && p.dsq < held[held_n-1].dsq) begin
          held_n--;
          insert_point(p);
        end
      end
      CMD_DRAIN: begin
        if (held_n == 0) begin
          r = '0;
          r.last = 1'b1;
          drained_q.push_back(r);
        end
        for (int unsigned i = 0; i < held_n; i++) begin
          r.found   = 1'b1;
          r.nb_x    = held[i].x;
          r.nb_y    = held[i].y;
          r.nb_z    = held[i].z;
          r.dist_sq = held[i].dsq;
          r.rank    = i[RANK_BITS-1:0];
          r.last    = (i + 1 == held_n);
          drained_q.push_back(r);
        end
        held_n = 0;
      end
      default: ;  // unused command, no effect
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      k_limit = KCFG_BITS'(KCFG_RESET);
      qx = '0; qy = '0; qz = '0;
      held_n = 0;
      drained_q.delete();
      fails_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) k_limit = cfg_data_i;
      if (push_i && !full_i) predict(in_i);
      if (pop_i && !empty_i) begin
        if (drained_q.size() == 0) begin
          $error("unexpected word from block");
          fails_o++;
        end else begin
          e = drained_q.pop_front();
          check_field("found",   e.found,   out_i.found);
          check_field("nb_x",    e.nb_x,    out_i.nb_x);
          check_field("nb_y",    e.nb_y,    out_i.nb_y);
          check_field("nb_z",    e.nb_z,    out_i.nb_z);
          check_field("dist_sq", e.dist_sq, out_i.dist_sq);
          check_field("rank",    e.rank,    out_i.rank);
          check_field("last",    e.last,    out_i.last);
        end
      end
    end
  end
endmodule

/* bench/tb_top.sv */
// Testbench top for the k-nearest-neighbor selector: clock, reset, stimulus
// and verdict. Depends on knn_pkg, k_nearest_neighbor_selector_top, knn_checker.
module tb_top;
  import knn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_WAIT = 24;  // distance pipe plus 8-deep job queue, with margin

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  in_word_t             in_w = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  out_word_t            out_w;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [KCFG_BITS-1:0] cfg_data = '0;
  int                   fails;
  int                   pending;
  bit                   calm = 1'b0;  // no idling on either side while set

  always #4 clk = ~clk;

  k_nearest_neighbor_selector_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .push_i(push), .full_o(full), .in_i(in_w),
    .empty_o(empty), .pop_i(pop), .out_o(out_w),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  knn_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .push_i(push), .full_i(full), .in_i(in_w),
    .empty_i(empty), .pop_i(pop), .out_i(out_w),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fails_o(fails), .pending_o(pending)
  );

  // Receiver stalls about 26 percent of the time unless in a calm stretch.
  always @(posedge clk) begin
    pop <= calm || ($urandom_range(99) >= 26);
  end

  // Hand one word over; push stays high from one word into the next
  // unless a gap is drawn.
  task automatic send(logic [1:0] cmd, logic [23:0] x, logic [23:0] y, logic [23:0] z);
    while (!calm && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_w <= '{command: cmd, x: x, y: y, z: z};
    do @(posedge clk); while (full);
  endtask

  // Let everything settle, then write max_neighbors.
  task automatic set_k(logic [KCFG_BITS-1:0] v);
    push <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    wait (pending == 0);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] rnd_coord();
    return 24'($urandom);
  endfunction

  // One query: start, n offers clustered near the query (ties likely) or
  // anywhere, then a drain.
  task automatic run_query(int n);
    logic [23:0] qx, qy, qz;
    int          spread;
    qx = rnd_coord(); qy = rnd_coord(); qz = rnd_coord();
    spread = $urandom_range(2) == 0 ? 3 : 4000;
    send(CMD_START, qx, qy, qz);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send(CMD_OFFER, rnd_coord(), rnd_coord(), rnd_coord());
      else
        send(CMD_OFFER, qx + 24'($urandom_range(2 * spread) - spread),
             qy + 24'($urandom_range(2 * spread) - spread),
             qz + 24'($urandom_range(2 * spread) - spread));
    end
    send(CMD_DRAIN, rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  // Random phase; the odd stray word (unused command, offer without start)
  // is mixed in as noise.
  task automatic random_phase(int words, int max_n);
    int sent;
    int n;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(7) == 0) begin
        send($urandom_range(9) < 5 ? CMD_UNUSED : CMD_OFFER, rnd_coord(), rnd_coord(),
             rnd_coord());
        sent++;
      end else begin
        n = $urandom_range(max_n);
        run_query(n);
        sent += n + 2;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: drain while empty, extremes and saturation, ties, unused command.
    send(CMD_DRAIN, 24'h0, 24'h0, 24'h0);
    send(CMD_START, 24'h800000, 24'h800000, 24'h800000);
    send(CMD_OFFER, 24'h7fffff, 24'h7fffff, 24'h7fffff);  // saturates
    send(CMD_OFFER, 24'h7fffff, 24'h800000, 24'h7fffff);  // saturates, tie
    send(CMD_OFFER, 24'h800000, 24'h800000, 24'h800000);  // distance 0
    send(CMD_OFFER, 24'h800001, 24'h800000, 24'h800000);
    send(CMD_OFFER, 24'h800000, 24'h800001, 24'h800000);  // tie with previous
    send(CMD_UNUSED, 24'hffffff, 24'hffffff, 24'hffffff);
    send(CMD_DRAIN, 24'hffffff, 24'h0, 24'h7fffff);
    send(CMD_START, 24'h0, 24'h0, 24'h0);
    send(CMD_OFFER, 24'h000005, 24'h0, 24'h0);
    send(CMD_OFFER, 24'hfffffb, 24'h0, 24'h0);
    send(CMD_OFFER, 24'h0, 24'h000003, 24'h0);
    send(CMD_OFFER, 24'h0, 24'h0, 24'hfffff9);

    // Lower the limit below the held count mid-query.
    set_k(7'd2);
    send(CMD_OFFER, 24'h000004, 24'h0, 24'h0);  // nearer than farthest, replaces it
    send(CMD_OFFER, 24'h000001, 24'h0, 24'h0);  // replaces farthest
    send(CMD_DRAIN, 24'h0, 24'h0, 24'h0);

    // Random phases over several limits, extremes included.
    set_k(7'd1);
    random_phase(20, 6);
    set_k(7'd64);
    calm = 1'b1;
    random_phase(30, 80);
    calm = 1'b0;
    set_k(7'd0);
    random_phase(15, 5);
    set_k(7'd127);
    random_phase(30, 70);
    set_k(7'($urandom_range(2, 20)));
    random_phase(25, 20);

    push <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
